// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is low
`define IDMM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Condition that must never hold at a clock edge
`define IDMM_ASSERT_NEVER(lbl, clk, rstn, cond) \
    `IDMM_ASSERT(lbl, clk, rstn, not (cond))

`endif

// ===== src/idmm_pkg.sv =====
// Shared widths, constants and handshake structs of the reciprocal multiplier block.
// Used by idmm_div, idmm_core and the top level; depends on nothing.
package idmm_pkg;

    localparam int WORD_W    = 32;
    localparam int QUO_W     = 34;
    localparam int IDX_W     = 7;
    localparam int SHIFT_W   = 6;
    localparam int PRE_W     = 5;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    localparam logic [SHIFT_W-1:0] PREC_SIGNED   = 6'd31;
    localparam logic [SHIFT_W-1:0] PREC_UNSIGNED = 6'd32;
    localparam logic [WORD_W-1:0]  T31           = 32'h8000_0000;

    // Request to the dual serial divider
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] d;
        logic [IDX_W-1:0]  top_idx;
        logic [IDX_W-1:0]  extra_idx;
    } t_div_req;

    // Quotients of the low and high bound
    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] q_lo;
        logic [QUO_W-1:0] q_hi;
    } t_div_rsp;

    // Request to the multiplier core
    typedef struct packed {
        logic               start;
        logic [WORD_W-1:0]  d;
        logic [SHIFT_W-1:0] prec;
    } t_core_req;

    // Multiplier and shift from the core
    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   m;
        logic [SHIFT_W-1:0] s;
    } t_core_rsp;

endpackage

// ===== src/idmm_div.sv =====
// Dual restoring divider, one quotient bit per cycle for both bounds at once.
// Depends on idmm_pkg.
module idmm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  idmm_pkg::t_div_req  i_req,
    output idmm_pkg::t_div_rsp  o_rsp
);
    import idmm_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_top;
    logic [IDX_W-1:0]    r_extra;
    logic [WORD_W-1:0]   r_d;
    logic [WORD_W-1:0]   r_rem_lo;
    logic [WORD_W-1:0]   r_rem_hi;
    logic [QUO_W-1:0]    r_q_lo;
    logic [QUO_W-1:0]    r_q_hi;

    logic                bit_lo;
    logic                bit_hi;
    logic [WORD_W:0]     sh_lo;
    logic [WORD_W:0]     sh_hi;
    logic [WORD_W:0]     dif_lo;
    logic [WORD_W:0]     dif_hi;
    logic                ge_lo;
    logic                ge_hi;

    // Numerator bits: one power of two for the low bound, two for the high bound
    assign bit_lo = (r_idx == r_top);
    assign bit_hi = bit_lo | (r_idx == r_extra);

    // Shift in the next numerator bit and trial-subtract the divisor
    assign sh_lo  = {r_rem_lo, bit_lo};
    assign sh_hi  = {r_rem_hi, bit_hi};
    assign dif_lo = sh_lo - {1'b0, r_d};
    assign dif_hi = sh_hi - {1'b0, r_d};
    assign ge_lo  = (sh_lo >= {1'b0, r_d});
    assign ge_hi  = (sh_hi >= {1'b0, r_d});

    // Step both divisions, one bit position per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy   <= 1'b1;
                r_idx    <= i_req.top_idx;
                r_top    <= i_req.top_idx;
                r_extra  <= i_req.extra_idx;
                r_d      <= i_req.d;
                r_rem_lo <= '0;
                r_rem_hi <= '0;
                r_q_lo   <= '0;
                r_q_hi   <= '0;
            end else if (r_busy) begin
                r_rem_lo <= ge_lo ? dif_lo[WORD_W-1:0] : sh_lo[WORD_W-1:0];
                r_rem_hi <= ge_hi ? dif_hi[WORD_W-1:0] : sh_hi[WORD_W-1:0];
                r_q_lo   <= {r_q_lo[QUO_W-2:0], ge_lo};
                r_q_hi   <= {r_q_hi[QUO_W-2:0], ge_hi};
                if (r_idx == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q_lo = r_q_lo;
    assign o_rsp.q_hi = r_q_hi;

endmodule

// ===== src/idmm_core.sv =====
// Multiplier core: bit-length count, bound division and serial halving of the bounds.
// Depends on idmm_pkg and idmm_div.
module idmm_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  idmm_pkg::t_core_req  i_req,
    output idmm_pkg::t_core_rsp  o_rsp
);
    import idmm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOG,
        ST_DIV,
        ST_HALVE
    } t_state;

    t_state              r_state;
    logic                r_done;
    logic                r_div_start;
    logic [WORD_W-1:0]   r_d;
    logic [WORD_W-1:0]   r_t;
    logic [SHIFT_W-1:0]  r_l;
    logic [SHIFT_W-1:0]  r_prec;
    logic [QUO_W-1:0]    r_lo;
    logic [QUO_W-1:0]    r_hi;

    t_div_req            div_req;
    t_div_rsp            div_rsp;
    logic [IDX_W-1:0]    top_idx;

    // Numerator exponents: 32 + l, and 32 + l - prec for the high bound
    assign top_idx           = IDX_W'(WORD_W) + IDX_W'(r_l);
    assign div_req.start     = r_div_start;
    assign div_req.d         = r_d;
    assign div_req.top_idx   = top_idx;
    assign div_req.extra_idx = top_idx - IDX_W'(r_prec);

    idmm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequence the bit count, the divisions and the halving
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_done      <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_done      <= 1'b0;
            r_div_start <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_req.start) begin
                        r_d     <= i_req.d;
                        r_t     <= i_req.d - 1'b1;
                        r_l     <= '0;
                        r_prec  <= i_req.prec;
                        r_state <= ST_LOG;
                    end
                end
                // Count the bits of d - 1
                ST_LOG: begin
                    if (r_t != '0) begin
                        r_t <= r_t >> 1;
                        r_l <= r_l + 1'b1;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_lo    <= div_rsp.q_lo;
                        r_hi    <= div_rsp.q_hi;
                        r_state <= ST_HALVE;
                    end
                end
                // Halve both bounds while l is nonzero and their halves still differ
                ST_HALVE: begin
                    if (r_l != '0 && r_lo[QUO_W-1:1] != r_hi[QUO_W-1:1]) begin
                        r_lo <= r_lo >> 1;
                        r_hi <= r_hi >> 1;
                        r_l  <= r_l - 1'b1;
                    end else begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.m    = r_hi;
    assign o_rsp.s    = r_l;

endmodule

// ===== src/invariant_divisor_magic_multiplier.sv =====
// Reciprocal multiplier generator for division by an invariant 32-bit divisor.
// An invalid divisor goes straight to the output register; any other divisor takes one core
// run, then for some unsigned divisors a trailing-zero strip and maybe a second run.
// One item at a time; the serial divider, one bit per cycle, sets the pace of a run.
// Reset: synchronous, active low; clears the sequencers and the output valid, no clearing pass.
// Depends on idmm_pkg and idmm_core.
module invariant_divisor_magic_multiplier (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [idmm_pkg::S_TDATA_W-1:0]     s_axis_tdata,   // [31:0] divisor
    input  logic [0:0]                         s_axis_tuser,   // [0] signed_mode
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] magic_value, [37:32] post_shift, [38] add_back, [43:39] pre_shift, [47:44] zero
    output logic [idmm_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic [0:0]                         m_axis_tuser    // [0] invalid
);
    import idmm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORE1,
        ST_STRIP,
        ST_CORE2,
        ST_FIN
    } t_state;

    t_state               r_state;
    logic                 r_core_start;
    logic [WORD_W-1:0]    r_core_d;
    logic [SHIFT_W-1:0]   r_core_prec;
    logic [WORD_W-1:0]    r_d;
    logic                 r_sgn;
    logic                 r_inv;
    logic [WORD_W-1:0]    r_odd;
    logic [PRE_W-1:0]     r_strip;
    logic [PRE_W-1:0]     r_pre;
    logic [QUO_W-1:0]     r_m;
    logic [SHIFT_W-1:0]   r_s;
    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic                 r_out_user;

    t_core_req            core_req;
    t_core_rsp            core_rsp;
    logic                 in_acc;
    logic                 in_bad;
    logic [WORD_W-1:0]    in_d;
    logic                 fin_add;
    logic [SHIFT_W-1:0]   fin_s;
    logic [M_TDATA_W-1:0] fin_data;

    assign core_req.start = r_core_start;
    assign core_req.d     = r_core_d;
    assign core_req.prec  = r_core_prec;

    idmm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (core_req),
        .o_rsp   (core_rsp)
    );

    // Accept an item only between runs
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_d          = s_axis_tdata[WORD_W-1:0];
    // Divisor 0 or 1, or signed divisor above 2^31
    assign in_bad = (in_d[WORD_W-1:1] == '0) ||
                    (s_axis_tuser[0] && in_d[WORD_W-1] && (in_d[WORD_W-2:0] != '0));

    // Work out add-back and the adjusted shift from the final multiplier
    always_comb begin
        fin_add = 1'b0;
        fin_s   = r_s;
        if (r_inv) begin
            fin_s = '0;
        end else if (r_sgn) begin
            fin_add = (r_m[QUO_W-1:WORD_W-1] != '0);
        end else if (r_m[QUO_W-1:WORD_W] != '0) begin
            fin_add = 1'b1;
            fin_s   = (r_s != '0) ? r_s - 1'b1 : '0;
        end
        fin_data = {4'b0000, r_pre, fin_add, fin_s, r_m[WORD_W-1:0]};
    end

    // Main sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_core_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_core_start <= 1'b0;
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_d   <= in_d;
                        r_sgn <= s_axis_tuser[0];
                        r_pre <= '0;
                        r_inv <= in_bad;
                        if (in_bad) begin
                            r_m     <= '0;
                            r_s     <= '0;
                            r_state <= ST_FIN;
                        end else begin
                            r_core_d     <= in_d;
                            r_core_prec  <= s_axis_tuser[0] ? PREC_SIGNED : PREC_UNSIGNED;
                            r_core_start <= 1'b1;
                            r_state      <= ST_CORE1;
                        end
                    end
                end
                ST_CORE1: begin
                    if (core_rsp.done) begin
                        r_m <= core_rsp.m;
                        r_s <= core_rsp.s;
                        if (!r_sgn && core_rsp.m[QUO_W-1:WORD_W] != '0) begin
                            r_odd   <= r_d;
                            r_strip <= '0;
                            r_state <= ST_STRIP;
                        end else begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                // Strip trailing zeros; if any, redo an odd part above 1 at lower precision
                ST_STRIP: begin
                    if (!r_odd[0]) begin
                        r_odd   <= r_odd >> 1;
                        r_strip <= r_strip + 1'b1;
                    end else if (r_strip != '0 && r_odd != WORD_W'(1)) begin
                        r_pre        <= r_strip;
                        r_core_d     <= r_odd;
                        r_core_prec  <= PREC_UNSIGNED - SHIFT_W'(r_strip);
                        r_core_start <= 1'b1;
                        r_state      <= ST_CORE2;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_CORE2: begin
                    if (core_rsp.done) begin
                        r_m     <= core_rsp.m;
                        r_s     <= core_rsp.s;
                        r_state <= ST_FIN;
                    end
                end
                // Hand the item over once the output register is free
                ST_FIN: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= fin_data;
                        r_out_user  <= r_inv;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_user;

endmodule

// ===== src/idmm_checker.sv =====
// Port-level checks of the reciprocal multiplier generator, bound to the top level.
// Depends on assert_macros.svh and the ports of invariant_divisor_magic_multiplier.
`include "assert_macros.svh"

module idmm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // Hold a stalled result
    `IDMM_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // One item at a time: ready drops after an accept
    `IDMM_ASSERT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)

    // An invalid divisor gives all-zero fields
    `IDMM_ASSERT_NEVER(a_invalid_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0] && (m_axis_tdata != 48'd0))

    // Post-shift stays within the word and padding stays zero
    `IDMM_ASSERT(a_shift_range, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata[37:32] <= 6'd32) && (m_axis_tdata[47:44] == 4'd0))

endmodule

bind invariant_divisor_magic_multiplier idmm_checker u_idmm_checker (.*);
